[rtl/core/dmn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distributed mutex node package
// Shared types, codes and widths for the mutual exclusion node.
// ----------------------------------------------------------------------------
package dmn_pkg;

    localparam int MAX_NODES   = 16;
    localparam int SCAN_W      = $clog2(MAX_NODES);
    localparam int ID_W        = 4;
    localparam int CLK_W       = 32;
    localparam int TALLY_W     = 5;
    localparam int SENT_W      = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [TALLY_W-1:0]   TALLY_MAX   = '1;
    localparam logic [SENT_W-1:0]    MAX_REPLIES = SENT_W'(15);
    localparam logic [SCAN_W-1:0]    SCAN_LAST   = SCAN_W'(MAX_NODES - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_LOCK    = 2'd0,
        CMD_UNLOCK  = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_REPLY   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_REPLY = 3'd0,
        ACT_BCAST = 3'd1,
        ACT_GRANT = 3'd2,
        ACT_REL   = 3'd3,
        ACT_REJ   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_REQ  = 2'd1,
        PH_HELD = 2'd2
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_GRANT = 5'b00100,
        S_SCAN  = 5'b01000,
        S_REL   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        ALU_INC    = 2'd0,
        ALU_MAXINC = 2'd1,
        ALU_CMP    = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [CLK_W-1:0]   a;
        logic [CLK_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [CLK_W-1:0]   sum;
        logic               lt;
        logic               eq;
    } alu_res_t;

    typedef struct packed {
        logic [ID_W-1:0]    self_id;
        logic [ID_W-1:0]    peer_count;
    } cfg_t;

endpackage

[rtl/core/distributed_mutex_node_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distributed mutex node
// One node of timestamp-ordered mutual exclusion with a logical clock.
// ----------------------------------------------------------------------------
// An accepted request is latched into the command registers and the execution state,
// from which each result is registered onto the ports. Lock, peer request, peer reply
// and a rejected command end there; a lock granted at once then goes to the grant state.
// An unlock from the held phase sweeps all 16 deferred bits, one per cycle, and then
// releases. No request is taken while busy; the receiver cannot stall the results.
// Reset clears the node to idle with the clock at one and both settings at zero.
module distributed_mutex_node_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [dmn_pkg::ID_W-1:0]          peer_id,
    input  logic [dmn_pkg::CLK_W-1:0]         peer_timestamp,
    input  logic                              cfg_we,
    input  logic [dmn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmn_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              strobe,
    output logic [2:0]                        action,
    output logic [dmn_pkg::ID_W-1:0]          dest_node,
    output logic [dmn_pkg::CLK_W-1:0]         stamp_out,
    output logic                              last
);

    logic [dmn_pkg::ID_W-1:0] self_id_reg, self_id_next;
    logic [dmn_pkg::ID_W-1:0] peer_count_reg, peer_count_next;
    dmn_pkg::cfg_t            cfg;
    dmn_pkg::alu_req_t        alu_req;
    dmn_pkg::alu_res_t        alu_res;

    always_comb
    begin
        self_id_next    = self_id_reg;
        peer_count_next = peer_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dmn_pkg::CFG_SELF_ID:
                begin
                    self_id_next = cfg_data;
                end
                dmn_pkg::CFG_PEER_COUNT:
                begin
                    peer_count_next = cfg_data;
                end
                default:
                begin
                    self_id_next = self_id_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg    <= '0;
            peer_count_reg <= '0;
        end
        else
        begin
            self_id_reg    <= self_id_next;
            peer_count_reg <= peer_count_next;
        end
    end

    assign cfg.self_id    = self_id_reg;
    assign cfg.peer_count = peer_count_reg;

    dmn_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    dmn_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .command        (command),
        .peer_id        (peer_id),
        .peer_timestamp (peer_timestamp),
        .cfg            (cfg),
        .alu_req        (alu_req),
        .alu_res        (alu_res),
        .busy           (busy),
        .strobe         (strobe),
        .action         (action),
        .dest_node      (dest_node),
        .stamp_out      (stamp_out),
        .last           (last)
    );

endmodule

[rtl/core/dmn_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distributed mutex node clock unit
// Shared 32-bit compare and increment unit used by the sequencer.
// ----------------------------------------------------------------------------
module dmn_alu (
    input  dmn_pkg::alu_req_t req,
    output dmn_pkg::alu_res_t res
);

    logic                    a_lt_b;
    logic [dmn_pkg::CLK_W-1:0] operand;

    assign a_lt_b = req.a < req.b;

    always_comb
    begin
        unique case (req.op)
            dmn_pkg::ALU_MAXINC:
            begin
                operand = a_lt_b ? req.b : req.a;
            end
            dmn_pkg::ALU_INC, dmn_pkg::ALU_CMP:
            begin
                operand = req.a;
            end
            default:
            begin
                operand = req.a;
            end
        endcase
    end

    assign res.sum = operand + dmn_pkg::CLK_W'(1);
    assign res.lt  = a_lt_b;
    assign res.eq  = req.a == req.b;

endmodule

[rtl/core/dmn_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distributed mutex node sequencer
// Holds the node state and steps each request through the shared clock unit.
// ----------------------------------------------------------------------------
module dmn_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    command,
    input  logic [dmn_pkg::ID_W-1:0]      peer_id,
    input  logic [dmn_pkg::CLK_W-1:0]     peer_timestamp,
    input  dmn_pkg::cfg_t                 cfg,
    output dmn_pkg::alu_req_t             alu_req,
    input  dmn_pkg::alu_res_t             alu_res,
    output logic                          busy,
    output logic                          strobe,
    output logic [2:0]                    action,
    output logic [dmn_pkg::ID_W-1:0]      dest_node,
    output logic [dmn_pkg::CLK_W-1:0]     stamp_out,
    output logic                          last
);

    dmn_pkg::state_t                  state_reg, state_next;
    dmn_pkg::phase_t                  phase_reg, phase_next;
    logic [dmn_pkg::CLK_W-1:0]        clock_reg, clock_next;
    logic [dmn_pkg::TALLY_W-1:0]      tally_reg, tally_next;
    logic [dmn_pkg::MAX_NODES-1:0]    mask_reg, mask_next;
    logic [dmn_pkg::SCAN_W-1:0]       idx_reg, idx_next;
    logic [dmn_pkg::SENT_W-1:0]       sent_reg, sent_next;

    dmn_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [dmn_pkg::ID_W-1:0]         pid_reg, pid_next;
    logic [dmn_pkg::CLK_W-1:0]        pts_reg, pts_next;

    logic                             strobe_reg, strobe_next;
    dmn_pkg::action_t                 action_reg, action_next;
    logic [dmn_pkg::ID_W-1:0]         dest_reg, dest_next;
    logic [dmn_pkg::CLK_W-1:0]        stamp_reg, stamp_next;
    logic                             last_reg, last_next;

    logic                             accept;
    logic                             pid_bad;
    logic [dmn_pkg::TALLY_W-1:0]      tally_inc;
    logic [dmn_pkg::MAX_NODES-1:0]    pid_bit;

    assign busy    = state_reg != dmn_pkg::S_IDLE;
    assign accept  = start && !busy;
    assign pid_bad = (pid_reg == cfg.self_id) || (32'(pid_reg) >= 32'(dmn_pkg::MAX_NODES));
    assign pid_bit = dmn_pkg::MAX_NODES'(1) << pid_reg;
    assign tally_inc = (tally_reg == dmn_pkg::TALLY_MAX) ? tally_reg
                                                         : tally_reg + dmn_pkg::TALLY_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        clock_next  = clock_reg;
        tally_next  = tally_reg;
        mask_next   = mask_reg;
        idx_next    = idx_reg;
        sent_next   = sent_reg;
        cmd_next    = cmd_reg;
        pid_next    = pid_reg;
        pts_next    = pts_reg;
        strobe_next = 1'b0;
        action_next = dmn_pkg::ACT_REPLY;
        dest_next   = '0;
        stamp_next  = '0;
        last_next   = 1'b0;
        alu_req.op  = dmn_pkg::ALU_INC;
        alu_req.a   = clock_reg;
        alu_req.b   = clock_reg;

        unique case (state_reg)
            dmn_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = dmn_pkg::cmd_t'(command);
                    pid_next   = peer_id;
                    pts_next   = peer_timestamp;
                    state_next = dmn_pkg::S_EXEC;
                end
            end
            dmn_pkg::S_EXEC:
            begin
                state_next = dmn_pkg::S_IDLE;
                unique case (cmd_reg)
                    dmn_pkg::CMD_LOCK:
                    begin
                        if (phase_reg != dmn_pkg::PH_IDLE)
                        begin
                            strobe_next = 1'b1;
                            action_next = dmn_pkg::ACT_REJ;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            clock_next  = alu_res.sum;
                            phase_next  = dmn_pkg::PH_REQ;
                            tally_next  = '0;
                            strobe_next = 1'b1;
                            action_next = dmn_pkg::ACT_BCAST;
                            stamp_next  = alu_res.sum;
                            if (cfg.peer_count == '0)
                            begin
                                state_next = dmn_pkg::S_GRANT;
                            end
                            else
                            begin
                                last_next = 1'b1;
                            end
                        end
                    end
                    dmn_pkg::CMD_UNLOCK:
                    begin
                        if (phase_reg != dmn_pkg::PH_HELD)
                        begin
                            strobe_next = 1'b1;
                            action_next = dmn_pkg::ACT_REJ;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            clock_next = alu_res.sum;
                            idx_next   = '0;
                            sent_next  = '0;
                            state_next = dmn_pkg::S_SCAN;
                        end
                    end
                    dmn_pkg::CMD_REQUEST:
                    begin
                        priority if (pid_bad)
                        begin
                            strobe_next = 1'b1;
                            action_next = dmn_pkg::ACT_REJ;
                            last_next   = 1'b1;
                        end
                        else if (phase_reg == dmn_pkg::PH_REQ)
                        begin
                            alu_req.op = dmn_pkg::ALU_CMP;
                            alu_req.a  = pts_reg;
                            if (alu_res.lt || (alu_res.eq && (pid_reg < cfg.self_id)))
                            begin
                                strobe_next = 1'b1;
                                action_next = dmn_pkg::ACT_REPLY;
                                dest_next   = pid_reg;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                mask_next = mask_reg | pid_bit;
                            end
                        end
                        else if (phase_reg == dmn_pkg::PH_HELD)
                        begin
                            mask_next = mask_reg | pid_bit;
                        end
                        else
                        begin
                            alu_req.op  = dmn_pkg::ALU_MAXINC;
                            alu_req.a   = pts_reg;
                            clock_next  = alu_res.sum;
                            strobe_next = 1'b1;
                            action_next = dmn_pkg::ACT_REPLY;
                            dest_next   = pid_reg;
                            last_next   = 1'b1;
                        end
                    end
                    dmn_pkg::CMD_REPLY:
                    begin
                        if (phase_reg == dmn_pkg::PH_REQ)
                        begin
                            tally_next = tally_inc;
                            if (tally_inc >= {1'b0, cfg.peer_count})
                            begin
                                phase_next  = dmn_pkg::PH_HELD;
                                strobe_next = 1'b1;
                                action_next = dmn_pkg::ACT_GRANT;
                                last_next   = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = dmn_pkg::S_IDLE;
                    end
                endcase
            end
            dmn_pkg::S_GRANT:
            begin
                phase_next  = dmn_pkg::PH_HELD;
                strobe_next = 1'b1;
                action_next = dmn_pkg::ACT_GRANT;
                last_next   = 1'b1;
                state_next  = dmn_pkg::S_IDLE;
            end
            dmn_pkg::S_SCAN:
            begin
                if (mask_reg[idx_reg] && (sent_reg < dmn_pkg::MAX_REPLIES))
                begin
                    strobe_next = 1'b1;
                    action_next = dmn_pkg::ACT_REPLY;
                    dest_next   = dmn_pkg::ID_W'(idx_reg);
                    sent_next   = sent_reg + dmn_pkg::SENT_W'(1);
                end
                if (idx_reg == dmn_pkg::SCAN_LAST)
                begin
                    state_next = dmn_pkg::S_REL;
                end
                else
                begin
                    idx_next = idx_reg + dmn_pkg::SCAN_W'(1);
                end
            end
            dmn_pkg::S_REL:
            begin
                mask_next   = '0;
                phase_next  = dmn_pkg::PH_IDLE;
                strobe_next = 1'b1;
                action_next = dmn_pkg::ACT_REL;
                last_next   = 1'b1;
                state_next  = dmn_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dmn_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dmn_pkg::S_IDLE;
            phase_reg  <= dmn_pkg::PH_IDLE;
            clock_reg  <= dmn_pkg::CLK_W'(1);
            tally_reg  <= '0;
            mask_reg   <= '0;
            idx_reg    <= '0;
            sent_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            clock_reg  <= clock_next;
            tally_reg  <= tally_next;
            mask_reg   <= mask_next;
            idx_reg    <= idx_next;
            sent_reg   <= sent_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pid_reg    <= pid_next;
        pts_reg    <= pts_next;
        action_reg <= action_next;
        dest_reg   <= dest_next;
        stamp_reg  <= stamp_next;
        last_reg   <= last_next;
    end

    assign strobe    = strobe_reg;
    assign action    = action_reg;
    assign dest_node = dest_reg;
    assign stamp_out = stamp_reg;
    assign last      = last_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == dmn_pkg::S_EXEC)
        else $error("accepted request did not enter execution");

    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg) != dmn_pkg::S_IDLE)
        else $error("result issued without a request in progress");

    a_grant_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && action_reg == dmn_pkg::ACT_GRANT) |-> phase_reg == dmn_pkg::PH_HELD)
        else $error("lock granted without entering the held phase");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dmn_pkg::S_REL |=> (mask_reg == '0 && phase_reg == dmn_pkg::PH_IDLE))
        else $error("release left deferred peers or the held phase behind");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dmn_pkg::S_SCAN |-> phase_reg == dmn_pkg::PH_HELD)
        else $error("deferred scan outside the held phase");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distributed mutex node testbench
// Drives lock, unlock, peer request and peer reply commands into the node,
// mostly as complete lock rounds with random timing, and checks every
// action that the node emits against a built-in model of the protocol.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        dmn_pkg::action_t               act;
        logic [dmn_pkg::ID_W-1:0]       dest;
        logic [dmn_pkg::CLK_W-1:0]      stamp;
        logic                           fin;
    } node_action_t;

    class mutex_scoreboard;
        logic [dmn_pkg::CLK_W-1:0]     lclock;
        dmn_pkg::phase_t               stage;
        logic [dmn_pkg::TALLY_W-1:0]   replies_seen;
        logic [dmn_pkg::MAX_NODES-1:0] waiting_peers;
        logic [dmn_pkg::ID_W-1:0]      my_id;
        logic [dmn_pkg::ID_W-1:0]      quorum;
        node_action_t                  expected_actions[$];
        int                            errors;

        function new();
            lclock        = dmn_pkg::CLK_W'(1);
            stage         = dmn_pkg::PH_IDLE;
            replies_seen  = '0;
            waiting_peers = '0;
            my_id         = '0;
            quorum        = '0;
            errors        = 0;
        endfunction

        function void set_reg(logic [dmn_pkg::CFG_IDX_W-1:0] idx,
                              logic [dmn_pkg::CFG_DATA_W-1:0] val);
            if (idx == dmn_pkg::CFG_SELF_ID)
                my_id = val;
            else if (idx == dmn_pkg::CFG_PEER_COUNT)
                quorum = val;
        endfunction

        function node_action_t make(dmn_pkg::action_t a, logic [dmn_pkg::ID_W-1:0] d,
                                    logic [dmn_pkg::CLK_W-1:0] s);
            node_action_t r;
            r.act   = a;
            r.dest  = d;
            r.stamp = s;
            r.fin   = 1'b0;
            return r;
        endfunction

        // Returns 1 when a peer reply arrives outside the requesting phase and so leaves the node untouched.
        function bit take_command(dmn_pkg::cmd_t c, logic [dmn_pkg::ID_W-1:0] pid,
                                  logic [dmn_pkg::CLK_W-1:0] ts);
            node_action_t outs[$];
            bit           ignored;
            bit           prio;
            ignored = 1'b0;
            case (c)
                dmn_pkg::CMD_LOCK:
                begin
                    if (stage != dmn_pkg::PH_IDLE)
                    begin
                        outs.push_back(make(dmn_pkg::ACT_REJ, '0, '0));
                    end
                    else
                    begin
                        lclock       = lclock + dmn_pkg::CLK_W'(1);
                        stage        = dmn_pkg::PH_REQ;
                        replies_seen = '0;
                        outs.push_back(make(dmn_pkg::ACT_BCAST, '0, lclock));
                        if (quorum == '0)
                        begin
                            stage = dmn_pkg::PH_HELD;
                            outs.push_back(make(dmn_pkg::ACT_GRANT, '0, '0));
                        end
                    end
                end
                dmn_pkg::CMD_UNLOCK:
                begin
                    if (stage != dmn_pkg::PH_HELD)
                    begin
                        outs.push_back(make(dmn_pkg::ACT_REJ, '0, '0));
                    end
                    else
                    begin
                        lclock = lclock + dmn_pkg::CLK_W'(1);
                        for (int i = 0; i < dmn_pkg::MAX_NODES; i++)
                            if (waiting_peers[i] && outs.size() < int'(dmn_pkg::MAX_REPLIES))
                                outs.push_back(make(dmn_pkg::ACT_REPLY,
                                                    dmn_pkg::ID_W'(i), '0));
                        waiting_peers = '0;
                        stage         = dmn_pkg::PH_IDLE;
                        outs.push_back(make(dmn_pkg::ACT_REL, '0, '0));
                    end
                end
                dmn_pkg::CMD_REQUEST:
                begin
                    if (pid == my_id || int'(pid) >= dmn_pkg::MAX_NODES)
                    begin
                        outs.push_back(make(dmn_pkg::ACT_REJ, '0, '0));
                    end
                    else if (stage == dmn_pkg::PH_REQ)
                    begin
                        prio = (ts < lclock) || (ts == lclock && pid < my_id);
                        if (prio)
                            outs.push_back(make(dmn_pkg::ACT_REPLY, pid, '0));
                        else
                            waiting_peers[pid] = 1'b1;
                    end
                    else if (stage == dmn_pkg::PH_HELD)
                    begin
                        waiting_peers[pid] = 1'b1;
                    end
                    else
                    begin
                        lclock = ((ts > lclock) ? ts : lclock) + dmn_pkg::CLK_W'(1);
                        outs.push_back(make(dmn_pkg::ACT_REPLY, pid, '0));
                    end
                end
                default:
                begin
                    if (stage != dmn_pkg::PH_REQ)
                    begin
                        ignored = 1'b1;
                    end
                    else
                    begin
                        if (replies_seen != dmn_pkg::TALLY_MAX)
                            replies_seen = replies_seen + dmn_pkg::TALLY_W'(1);
                        if (replies_seen >= dmn_pkg::TALLY_W'(quorum))
                        begin
                            stage = dmn_pkg::PH_HELD;
                            outs.push_back(make(dmn_pkg::ACT_GRANT, '0, '0));
                        end
                    end
                end
            endcase
            if (outs.size() > 0)
                outs[outs.size() - 1].fin = 1'b1;
            foreach (outs[i])
                expected_actions.push_back(outs[i]);
            return ignored;
        endfunction

        function void match_action(dmn_pkg::action_t a, logic [dmn_pkg::ID_W-1:0] d,
                                   logic [dmn_pkg::CLK_W-1:0] s, logic f);
            node_action_t e;
            if (expected_actions.size() == 0)
            begin
                $error("action %0d arrived with nothing outstanding", a);
                errors++;
                return;
            end
            e = expected_actions.pop_front();
            if (a !== e.act)
            begin
                $error("action: expected %0d, actual %0d", e.act, a);
                errors++;
            end
            if (d !== e.dest)
            begin
                $error("dest_node: expected %0d, actual %0d", e.dest, d);
                errors++;
            end
            if (s !== e.stamp)
            begin
                $error("stamp_out: expected %0h, actual %0h", e.stamp, s);
                errors++;
            end
            if (f !== e.fin)
            begin
                $error("last: expected %0d, actual %0d", e.fin, f);
                errors++;
            end
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         command;
    logic [dmn_pkg::ID_W-1:0]           peer_id;
    logic [dmn_pkg::CLK_W-1:0]          peer_timestamp;
    logic                               cfg_we;
    logic [dmn_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [dmn_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                               strobe;
    logic [2:0]                         action;
    logic [dmn_pkg::ID_W-1:0]           dest_node;
    logic [dmn_pkg::CLK_W-1:0]          stamp_out;
    logic                               last;

    mutex_scoreboard sb;
    int              counted_requests;
    bit              gaps_on;
    int              quiet_cycles;

    distributed_mutex_node_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .peer_id        (peer_id),
        .peer_timestamp (peer_timestamp),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .strobe         (strobe),
        .action         (action),
        .dest_node      (dest_node),
        .stamp_out      (stamp_out),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.match_action(dmn_pkg::action_t'(action), dest_node, stamp_out, last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= 2000)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function logic [dmn_pkg::CLK_W-1:0] near_stamp();
        return sb.lclock + dmn_pkg::CLK_W'($urandom_range(0, 4)) - dmn_pkg::CLK_W'(2);
    endfunction

    task automatic issue(dmn_pkg::cmd_t c, logic [dmn_pkg::ID_W-1:0] pid,
                         logic [dmn_pkg::CLK_W-1:0] ts);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start          <= 1'b1;
        command        <= c;
        peer_id        <= pid;
        peer_timestamp <= ts;
        do
            @(posedge clk);
        while (busy);
        if (!sb.take_command(c, pid, ts))
            counted_requests++;
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_reg(logic [dmn_pkg::CFG_IDX_W-1:0] idx,
                             logic [dmn_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic noise_round();
        repeat ($urandom_range(1, 6))
            issue(dmn_pkg::cmd_t'($urandom_range(0, 3)), dmn_pkg::ID_W'($urandom_range(0, 15)),
                  ($urandom_range(0, 1) == 1) ? $urandom : near_stamp());
    endtask

    task automatic lock_round();
        int steps;
        int pick;
        repeat ($urandom_range(0, 2))
            issue(dmn_pkg::CMD_REQUEST, dmn_pkg::ID_W'($urandom_range(0, 15)),
                  ($urandom_range(0, 1) == 1) ? $urandom : near_stamp());
        issue(dmn_pkg::CMD_LOCK, dmn_pkg::ID_W'($urandom_range(0, 15)), $urandom);
        steps = 0;
        while (sb.stage == dmn_pkg::PH_REQ && steps < 40)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                issue(dmn_pkg::CMD_REPLY, dmn_pkg::ID_W'($urandom_range(0, 15)), $urandom);
            else if (pick < 9)
                issue(dmn_pkg::CMD_REQUEST, dmn_pkg::ID_W'($urandom_range(0, 15)),
                      near_stamp());
            else
                issue(dmn_pkg::cmd_t'($urandom_range(0, 1)),
                      dmn_pkg::ID_W'($urandom_range(0, 15)), $urandom);
            steps++;
        end
        if (sb.stage == dmn_pkg::PH_HELD)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                for (int k = 0; k < dmn_pkg::MAX_NODES; k++)
                    issue(dmn_pkg::CMD_REQUEST, dmn_pkg::ID_W'(k), $urandom);
            end
            else
            begin
                repeat ($urandom_range(0, 5))
                    issue(dmn_pkg::CMD_REQUEST, dmn_pkg::ID_W'($urandom_range(0, 15)),
                          $urandom);
            end
            if ($urandom_range(0, 3) == 0)
                issue(dmn_pkg::CMD_LOCK, dmn_pkg::ID_W'($urandom_range(0, 15)), $urandom);
            issue(dmn_pkg::CMD_UNLOCK, dmn_pkg::ID_W'($urandom_range(0, 15)), $urandom);
        end
    endtask

    task automatic random_settings();
        int pick;
        settle();
        pick = $urandom_range(0, 3);
        write_reg(dmn_pkg::CFG_SELF_ID, (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15
                  : dmn_pkg::CFG_DATA_W'($urandom_range(0, 15)));
        pick = $urandom_range(0, 7);
        write_reg(dmn_pkg::CFG_PEER_COUNT, (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15
                  : dmn_pkg::CFG_DATA_W'($urandom_range(1, 4)));
    endtask

    initial
    begin
        sb               = new();
        counted_requests = 0;
        gaps_on          = 1'b1;
        quiet_cycles     = 0;
        rst_n            = 1'b0;
        start            = 1'b0;
        command          = dmn_pkg::CMD_LOCK;
        peer_id          = '0;
        peer_timestamp   = '0;
        cfg_we           = 1'b0;
        cfg_index        = dmn_pkg::CFG_SELF_ID;
        cfg_data         = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // With no peers the lock is granted on the spot.
        issue(dmn_pkg::CMD_LOCK, 4'd0, 32'd0);
        issue(dmn_pkg::CMD_LOCK, 4'd0, 32'd0);
        issue(dmn_pkg::CMD_REQUEST, 4'd0, 32'd5);
        issue(dmn_pkg::CMD_REQUEST, 4'd15, 32'd0);
        issue(dmn_pkg::CMD_REPLY, 4'd3, 32'd0);
        issue(dmn_pkg::CMD_UNLOCK, 4'd0, 32'd0);
        issue(dmn_pkg::CMD_UNLOCK, 4'd0, 32'd0);
        issue(dmn_pkg::CMD_REPLY, 4'd3, 32'd0);
        // The clock wraps through zero here.
        issue(dmn_pkg::CMD_REQUEST, 4'd5, 32'hFFFF_FFFF);
        issue(dmn_pkg::CMD_REQUEST, 4'd3, 32'd0);
        settle();
        write_reg(dmn_pkg::CFG_SELF_ID, 4'd15);
        write_reg(dmn_pkg::CFG_PEER_COUNT, 4'd15);
        issue(dmn_pkg::CMD_LOCK, 4'd0, 32'd0);
        issue(dmn_pkg::CMD_REQUEST, 4'd14, sb.lclock);
        issue(dmn_pkg::CMD_REQUEST, 4'd0, sb.lclock);
        issue(dmn_pkg::CMD_REQUEST, 4'd7, sb.lclock + 32'd1);
        issue(dmn_pkg::CMD_REQUEST, 4'd7, sb.lclock - 32'd1);
        issue(dmn_pkg::CMD_REQUEST, 4'd7, 32'hFFFF_FFFF);
        issue(dmn_pkg::CMD_REPLY, 4'd1, 32'd0);
        issue(dmn_pkg::CMD_REPLY, 4'd2, 32'd0);
        issue(dmn_pkg::CMD_REPLY, 4'd3, 32'd0);
        // Lowering the peer count mid-request lets the next reply grant.
        settle();
        write_reg(dmn_pkg::CFG_PEER_COUNT, 4'd2);
        issue(dmn_pkg::CMD_REPLY, 4'd4, 32'd0);
        issue(dmn_pkg::CMD_UNLOCK, 4'd0, 32'd0);
        settle();
        write_reg(dmn_pkg::CFG_SELF_ID, 4'd0);
        write_reg(dmn_pkg::CFG_PEER_COUNT, 4'd1);

        while (counted_requests < 295)
        begin
            if (counted_requests > 250)
                gaps_on = 1'b0;
            if ($urandom_range(0, 5) == 0)
                random_settings();
            if ($urandom_range(0, 3) == 0)
                noise_round();
            else
                lock_round();
        end

        settle();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[files.f]
rtl/core/dmn_pkg.sv
rtl/core/dmn_alu.sv
rtl/core/dmn_ctrl.sv
rtl/core/distributed_mutex_node_unit.sv
test/tb.sv
